[rtl/brbop_pkg.sv]
// Shared types and constants for the byte ring buffer with overwrite and peek.
// Holds the action codes and the fixed field widths; depends on nothing.
`default_nettype none

package brbop_pkg;

	// Fixed widths of the transaction fields.
	localparam int ACTION_W  = 3;
	localparam int BYTE_W    = 8;
	localparam int AMOUNT_W  = 11;
	localparam int COUNT_W   = 11;

	// Default number of byte entries in the ring.
	localparam int DEPTH_DEF = 1024;

	// Action codes carried by each input transaction.
	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE     = 3'd0,
		ACT_OVERWRITE = 3'd1,
		ACT_READ      = 3'd2,
		ACT_PEEK      = 3'd3,
		ACT_SKIP      = 3'd4,
		ACT_CLEAR     = 3'd5
	} act_t;

endpackage

`default_nettype wire

[rtl/brbop_mem.sv]
// Byte storage of the ring: one write port and one read port with registered read data.
// Depends on brbop_pkg for the byte width.
`default_nettype none

module brbop_mem #(
	parameter int DEPTH = brbop_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [brbop_pkg::BYTE_W-1:0] wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic      [brbop_pkg::BYTE_W-1:0] rdata_s1
);
	import brbop_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];

	// Write port; entries are never cleared since only held bytes are read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/brbop_ctrl.sv]
// Head index and fill count of the ring, action decode, memory port control and
// the result register. Depends on brbop_pkg for action codes and field widths.
`default_nettype none

module brbop_ctrl #(
	parameter int DEPTH = brbop_pkg::DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [brbop_pkg::ACTION_W-1:0] action,
	input  wire logic [brbop_pkg::AMOUNT_W-1:0] amount,
	output logic                                mem_we,
	output logic      [$clog2(DEPTH)-1:0]       mem_waddr,
	output logic                                mem_re,
	output logic      [$clog2(DEPTH)-1:0]       mem_raddr,
	output logic                                strobe_s1,
	output logic                                sel_s1,
	output logic                                ok_s1,
	output logic      [brbop_pkg::COUNT_W-1:0]  done_s1,
	output logic      [brbop_pkg::COUNT_W-1:0]  fill_s1
);
	import brbop_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int W     = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;

	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
	localparam logic [W-1:0]     WIDE_ONE  = W'(1);
	localparam logic [PTR_W:0]   SUM_DEPTH = (PTR_W+1)'(DEPTH);

	// Bring a sum below twice the depth back into the ring.
	function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] sum);
		logic [PTR_W:0] diff;
		diff = sum - SUM_DEPTH;
		return (sum >= SUM_DEPTH) ? diff[PTR_W-1:0] : sum[PTR_W-1:0];
	endfunction

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;

	act_t             act;
	logic [W-1:0]     fill_x;
	logic [W-1:0]     amt_x;
	logic [W-1:0]     skip_w;
	logic [CNT_W-1:0] skip_c;
	logic             full;
	logic             empty;
	logic             peek_hit;
	logic [CNT_W-1:0] off;
	logic [PTR_W:0]   sum;
	logic [PTR_W-1:0] pos;

	logic [PTR_W-1:0] head_n;
	logic [CNT_W-1:0] fill_n;
	logic             we_c;
	logic [PTR_W-1:0] waddr_c;
	logic             rd_c;
	logic [PTR_W-1:0] raddr_c;
	logic             ok_c;
	logic [W-1:0]     done_c;
	logic [W-1:0]     fill_nx;

	// Status of the ring and the saturated skip count.
	always_comb begin
		act      = act_t'(action);
		fill_x   = W'(fill_q);
		amt_x    = W'(amount);
		full     = (fill_q == CNT_FULL);
		empty    = (fill_q == '0);
		peek_hit = (amt_x < fill_x);
		skip_w   = (amt_x > fill_x) ? fill_x : amt_x;
		skip_c   = skip_w[CNT_W-1:0];
	end

	// One shared adder moves the head or finds the tail or peek position.
	always_comb begin
		case (act)
			ACT_WRITE:     off = fill_q;
			ACT_OVERWRITE: off = full ? CNT_ONE : fill_q;
			ACT_READ:      off = CNT_ONE;
			ACT_PEEK:      off = peek_hit ? amt_x[CNT_W-1:0] : '0;
			ACT_SKIP:      off = skip_c;
			default:       off = '0;
		endcase
		sum = {1'b0, head_q} + (PTR_W+1)'(off);
		pos = wrap(sum);
	end

	// Action decode: next state, memory access and result fields.
	always_comb begin
		head_n  = head_q;
		fill_n  = fill_q;
		we_c    = 1'b0;
		waddr_c = pos;
		rd_c    = 1'b0;
		raddr_c = pos;
		ok_c    = 1'b0;
		done_c  = '0;
		case (act)
			ACT_WRITE: begin
				if (!full) begin
					we_c   = 1'b1;
					fill_n = fill_q + CNT_ONE;
					ok_c   = 1'b1;
					done_c = WIDE_ONE;
				end
			end
			ACT_OVERWRITE: begin
				we_c   = 1'b1;
				ok_c   = 1'b1;
				done_c = WIDE_ONE;
				if (full) begin
					// The oldest byte is replaced and the head steps past it.
					waddr_c = head_q;
					head_n  = pos;
				end else begin
					fill_n = fill_q + CNT_ONE;
				end
			end
			ACT_READ: begin
				if (!empty) begin
					rd_c    = 1'b1;
					raddr_c = head_q;
					head_n  = pos;
					fill_n  = fill_q - CNT_ONE;
					ok_c    = 1'b1;
					done_c  = WIDE_ONE;
				end
			end
			ACT_PEEK: begin
				if (peek_hit) begin
					rd_c   = 1'b1;
					ok_c   = 1'b1;
					done_c = WIDE_ONE;
				end
			end
			ACT_SKIP: begin
				head_n = pos;
				fill_n = fill_q - skip_c;
				ok_c   = 1'b1;
				done_c = skip_w;
			end
			ACT_CLEAR: begin
				head_n = '0;
				fill_n = '0;
				ok_c   = 1'b1;
			end
			default: begin
			end
		endcase
		fill_nx = W'(fill_n);
	end

	assign mem_we    = accept && we_c;
	assign mem_waddr = waddr_c;
	assign mem_re    = accept && rd_c;
	assign mem_raddr = raddr_c;

	// Ring state and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fill_q    <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= accept;
			if (accept) begin
				head_q <= head_n;
				fill_q <= fill_n;
			end
		end
	end

	// Result payload, captured with each accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1  <= rd_c;
			ok_s1   <= ok_c;
			done_s1 <= done_c[COUNT_W-1:0];
			fill_s1 <= fill_nx[COUNT_W-1:0];
		end
	end

	// The fill count never exceeds the ring size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_FULL)
		else $error("fill count beyond ring size");

	// The head always points inside the ring.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < PTR_W'(DEPTH - 1) || head_q == PTR_W'(DEPTH - 1))
		else $error("head index outside ring");

	// A write to a full ring leaves head and fill untouched.
	a_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == ACT_WRITE && full) |=> (fill_q == CNT_FULL && $stable(head_q)))
		else $error("write to full ring changed state");

	// Every accepted transaction yields exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> strobe_s1)
		else $error("accepted transaction produced no result");

	// A byte is returned only together with a successful single-byte count.
	a_sel_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_s1 && sel_s1) |-> (ok_s1 && done_s1 == COUNT_W'(1)))
		else $error("returned byte without success");

endmodule

`default_nettype wire

[rtl/byte_ring_buffer_overwrite_peek.sv]
// Top level of the byte ring buffer with overwrite and peek.
// Depends on brbop_pkg, brbop_ctrl and brbop_mem.
//
// A ring of DEPTH bytes with write, overwrite, read, peek, skip and clear
// actions. A transaction is taken on every clock edge where start is high;
// busy is never raised, so one transaction enters per cycle. Its result
// appears on the following cycle with strobe high for exactly one cycle, and
// the receiver must take it then. The byte comes from the registered read port
// of the byte memory, which has one write and one read port.
// The store needs no clearing after reset: only bytes that were written are
// ever returned.
`default_nettype none

module byte_ring_buffer_overwrite_peek #(
	parameter int DEPTH = brbop_pkg::DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [brbop_pkg::ACTION_W-1:0] action,
	input  wire logic [brbop_pkg::BYTE_W-1:0]   wr_byte,
	input  wire logic [brbop_pkg::AMOUNT_W-1:0] amount,
	output logic                                strobe,
	output logic      [brbop_pkg::BYTE_W-1:0]   rd_byte,
	output logic                                ok,
	output logic      [brbop_pkg::COUNT_W-1:0]  done_count,
	output logic      [brbop_pkg::COUNT_W-1:0]  fill_level
);
	import brbop_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic              accept;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr;
	logic              mem_re;
	logic [PTR_W-1:0]  mem_raddr;
	logic [BYTE_W-1:0] rdata_s1;
	logic              sel_s1;

	// Every action completes in one pass, so the block is always ready.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	brbop_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.amount    (amount),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.strobe_s1 (strobe),
		.sel_s1    (sel_s1),
		.ok_s1     (ok),
		.done_s1   (done_count),
		.fill_s1   (fill_level)
	);

	brbop_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk      (clk),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (wr_byte),
		.re       (mem_re),
		.raddr    (mem_raddr),
		.rdata_s1 (rdata_s1)
	);

	// Only a successful read or peek returns a byte.
	assign rd_byte = sel_s1 ? rdata_s1 : '0;

endmodule

`default_nettype wire
